// File: src/mllr_pkg.sv
package mllr_pkg;

   // Default sizing
   localparam int DEF_CHANNELS    = 16;
   localparam int DEF_WINDOW_LOG2 = 4;
   localparam int DEF_SAMPLE_BITS = 12;

   // Fixed field widths
   localparam int CH_BITS  = 4;
   localparam int SMP_BITS = 12;
   localparam int LVL_BITS = 16;
   localparam int AVG_BITS = 12;
   localparam int CSR_IDX_BITS = 1;

   // Drive constants
   localparam logic [LVL_BITS-1:0] RESET_LEVEL   = 16'd4700;
   localparam logic [LVL_BITS-1:0] RESET_CEILING = 16'd5000;
   localparam logic [LVL_BITS-1:0] FULL_DRIVE    = 16'hFFFF;

   // floor(x/10) == (x * 52429) >> 19 for every 16-bit x
   localparam logic [16:0] RECIP_TEN   = 17'd52429;
   localparam int          RECIP_SHIFT = 19;

   // Front-to-back job queue
   localparam int QUEUE_DEPTH = 4;

   // Command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TARGET = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_CEILING  = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REGULATE = 1'b1;

   typedef struct packed {
      logic                command;
      logic [CH_BITS-1:0]  channel;
      logic [SMP_BITS-1:0] sample;
      logic [LVL_BITS-1:0] target;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]  out_channel;
      logic                drive_update;
      logic [LVL_BITS-1:0] drive_level;
      logic [AVG_BITS-1:0] average;
   } rsp_type;

   // Classification done by the front end
   typedef enum logic [1:0] {
      KIND_SAMPLE,
      KIND_BLOCK_END,
      KIND_TARGET,
      KIND_IGNORE
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [CH_BITS-1:0]  channel;
      logic [AVG_BITS-1:0] avg;
      logic [LVL_BITS-1:0] target;
   } job_type;

endpackage

// File: src/multichannel_light_level_regulator.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mllr_pkg::req_type
// rsp_      out        rsp_valid/rsp_stall  mllr_pkg::rsp_type
// csr_      in         csr_write            csr_index, csr_wdata
//
// One request per cycle sustained while the job queue is not full; a taken request
// passes through the job queue, then two back stages and the result register.
// Per-channel sums update in the front; the drive level is read and
// written in the last back stage, so back-to-back requests need no forwarding.
// Synchronous active-high reset initialises all per-channel state; no clearing pass.
// req_stall rises only when the four-entry job queue is full; rsp_stall holds the
// back pipeline while the front keeps filling the queue.
module multichannel_light_level_regulator #(
   parameter int CHANNELS    = mllr_pkg::DEF_CHANNELS,
   parameter int WINDOW_LOG2 = mllr_pkg::DEF_WINDOW_LOG2,
   parameter int SAMPLE_BITS = mllr_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  mllr_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output mllr_pkg::rsp_type                 rsp_data,
   input  logic                              csr_write,
   input  logic [mllr_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [mllr_pkg::LVL_BITS-1:0]     csr_wdata
);
   import mllr_pkg::*;

   logic [LVL_BITS-1:0] ceiling_ff;
   logic                regulate_ff;

   logic    push, pop, full, empty;
   job_type push_data, head;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ceiling_ff  <= RESET_CEILING;
         regulate_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CEILING:  ceiling_ff  <= csr_wdata;
            CSR_REGULATE: regulate_ff <= csr_wdata[0];
            default:      ceiling_ff  <= ceiling_ff;
         endcase
      end
   end

   assign req_stall = full;

   mllr_front #(
      .CHANNELS    (CHANNELS),
      .WINDOW_LOG2 (WINDOW_LOG2),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .queue_full (full),
      .push       (push),
      .push_data  (push_data)
   );

   mllr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (full),
      .empty     (empty),
      .head      (head)
   );

   mllr_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (!empty),
      .job           (head),
      .pop           (pop),
      .drive_ceiling (ceiling_ff),
      .regulation_on (regulate_ff),
      .rsp_valid     (rsp_valid),
      .rsp_data      (rsp_data),
      .rsp_stall     (rsp_stall)
   );

endmodule

// File: src/mllr_front.sv
module mllr_front #(
   parameter int CHANNELS    = 16,
   parameter int WINDOW_LOG2 = 4,
   parameter int SAMPLE_BITS = 12
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  mllr_pkg::req_type req_data,
   input  logic              queue_full,
   output logic              push,
   output mllr_pkg::job_type push_data
);
   import mllr_pkg::*;

   localparam int STORE_DEPTH = (CHANNELS < (1 << CH_BITS)) ? CHANNELS : (1 << CH_BITS);
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int SUM_W = SMP_BITS + WINDOW_LOG2;
   localparam logic [SMP_BITS-1:0] SMP_MASK = SMP_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);

   logic [SUM_W-1:0]       sum_ff   [STORE_DEPTH];
   logic [WINDOW_LOG2-1:0] count_ff [STORE_DEPTH];

   logic [IDX_W-1:0]    idx;
   logic                in_range;
   logic [SMP_BITS-1:0] smp;
   logic [SUM_W-1:0]    sum_in;
   logic                last;

   // Classify the request and form the running sum
   always_comb begin
      idx      = IDX_W'(req_data.channel);
      in_range = 32'(req_data.channel) < 32'(CHANNELS);
      smp      = req_data.sample & SMP_MASK;
      sum_in   = sum_ff[idx] + SUM_W'(smp);
      last     = (count_ff[idx] == {WINDOW_LOG2{1'b1}});
      push     = req_valid && !queue_full;

      push_data.channel = req_data.channel;
      push_data.target  = req_data.target;
      push_data.avg     = AVG_BITS'(sum_in >> WINDOW_LOG2) & SMP_MASK;
      if (!in_range) begin
         push_data.kind = KIND_IGNORE;
      end else if (req_data.command == CMD_TARGET) begin
         push_data.kind = KIND_TARGET;
      end else if (last) begin
         push_data.kind = KIND_BLOCK_END;
      end else begin
         push_data.kind = KIND_SAMPLE;
      end
   end

   // Per-channel block accumulation
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
         end
      end else if (push && in_range && req_data.command == CMD_SAMPLE) begin
         if (last) begin
            sum_ff[idx]   <= '0;
            count_ff[idx] <= '0;
         end else begin
            sum_ff[idx]   <= sum_in;
            count_ff[idx] <= count_ff[idx] + 1'b1;
         end
      end
   end

endmodule

// File: src/mllr_queue.sv
module mllr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mllr_pkg::job_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              empty,
   output mllr_pkg::job_type head
);
   import mllr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: src/mllr_back.sv
module mllr_back #(
   parameter int CHANNELS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          job_valid,
   input  mllr_pkg::job_type             job,
   output logic                          pop,
   input  logic [mllr_pkg::LVL_BITS-1:0] drive_ceiling,
   input  logic                          regulation_on,
   output logic                          rsp_valid,
   output mllr_pkg::rsp_type             rsp_data,
   input  logic                          rsp_stall
);
   import mllr_pkg::*;

   localparam int STORE_DEPTH = (CHANNELS < (1 << CH_BITS)) ? CHANNELS : (1 << CH_BITS);
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

   typedef struct packed {
      kind_type            kind;
      logic [CH_BITS-1:0]  channel;
      logic [AVG_BITS-1:0] avg;
      logic                full_drive;
      logic                up;
      logic                down;
      logic [LVL_BITS-1:0] amount;
   } stage_type;

   logic [LVL_BITS-1:0] target_ff [STORE_DEPTH];
   logic [AVG_BITS-1:0] avg_ff    [STORE_DEPTH];
   logic [LVL_BITS-1:0] level_ff  [STORE_DEPTH];

   logic      s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   stage_type s1_ff, s1_in, s2_ff, s2_in;
   rsp_type   rsp_data_ff, rsp_in;

   logic                adv;
   logic [IDX_W-1:0]    a_idx, c_idx;
   logic [LVL_BITS-1:0] tgt, avg16;
   logic [32:0]         prod;
   logic [LVL_BITS-1:0] lvl_cur, lvl_next;
   logic [LVL_BITS:0]   lvl_up;
   logic                write_lvl;

   // Whole back pipeline moves when the result slot frees up
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign pop       = adv && job_valid;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Stage A: target/average lookup and error against target
   always_comb begin
      a_idx = IDX_W'(job.channel);
      tgt   = target_ff[a_idx];
      avg16 = LVL_BITS'(job.avg);

      s1_in.kind       = job.kind;
      s1_in.channel    = job.channel;
      s1_in.avg        = (job.kind == KIND_BLOCK_END) ? job.avg : avg_ff[a_idx];
      s1_in.full_drive = (tgt == '0) || !regulation_on;
      s1_in.up         = avg16 > tgt;
      s1_in.down       = avg16 < tgt;
      s1_in.amount     = (avg16 > tgt) ? (avg16 - tgt) : (tgt - avg16);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            target_ff[i] <= '0;
            avg_ff[i]    <= '0;
         end
      end else if (pop) begin
         if (job.kind == KIND_TARGET) begin
            target_ff[a_idx] <= job.target;
         end
         if (job.kind == KIND_BLOCK_END) begin
            avg_ff[a_idx] <= job.avg;
         end
      end
   end

   // Stage B: step = error / 10 by reciprocal multiply
   always_comb begin
      prod         = s1_ff.amount * RECIP_TEN;
      s2_in        = s1_ff;
      s2_in.amount = LVL_BITS'(prod >> RECIP_SHIFT);
   end

   // Stage C: drive level update and result
   always_comb begin
      c_idx     = IDX_W'(s2_ff.channel);
      lvl_cur   = level_ff[c_idx];
      lvl_up    = {1'b0, lvl_cur} + {1'b0, s2_ff.amount};
      lvl_next  = lvl_cur;
      write_lvl = 1'b0;

      rsp_in.out_channel  = s2_ff.channel;
      rsp_in.drive_update = 1'b0;
      rsp_in.drive_level  = lvl_cur;
      rsp_in.average      = s2_ff.avg;

      unique case (s2_ff.kind)
         KIND_IGNORE: begin
            rsp_in.drive_level = '0;
            rsp_in.average     = '0;
         end
         KIND_BLOCK_END: begin
            if (s2_ff.full_drive) begin
               rsp_in.drive_update = 1'b1;
               rsp_in.drive_level  = FULL_DRIVE;
            end else if (s2_ff.up || s2_ff.down) begin
               if (s2_ff.up) begin
                  lvl_next = (lvl_up > {1'b0, drive_ceiling}) ? drive_ceiling
                                                              : lvl_up[LVL_BITS-1:0];
               end else begin
                  lvl_next = (lvl_cur < s2_ff.amount) ? '0 : (lvl_cur - s2_ff.amount);
               end
               write_lvl           = 1'b1;
               rsp_in.drive_update = 1'b1;
               rsp_in.drive_level  = lvl_next;
            end
         end
         default: begin
            rsp_in.drive_update = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) begin
            level_ff[i] <= RESET_LEVEL;
         end
      end else if (adv && s2_valid_ff && write_lvl) begin
         level_ff[c_idx] <= lvl_next;
      end
   end

   // Pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= job_valid;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // Pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff       <= s1_in;
         s2_ff       <= s2_in;
         rsp_data_ff <= rsp_in;
      end
   end

endmodule
